/* hdl/tcw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg - shared types and constants of the text console writer
// Grid geometry, character codes, the command passed from the front end to
// the back end, and the result record.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// grid geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	// field widths of the ports
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int ADDR_W = $clog2(CELL_COUNT);

	// command queue between front and back end
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// opcodes
	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// character codes and attributes
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_RETURN  = 8'd13;
	localparam logic [7:0] CHAR_BLANK   = 8'h20;
	localparam logic [7:0] ATTR_DEFAULT = 8'h07;
	localparam logic [15:0] CELL_RESET  = {ATTR_DEFAULT, CHAR_BLANK};

	// one classified request, ready for the cell store
	typedef struct packed {
		logic              wr_en;       // write one cell
		logic              rd_en;       // read one cell (in range)
		logic              blank;       // blank one physical row after any write
		logic [ADDR_W-1:0] addr;        // cell address for write or read
		logic [15:0]       data;        // attribute : character
		logic [ADDR_W-1:0] blank_base;  // first cell of the row to blank
		logic [7:0]        blank_attr;
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
		logic              scrolled;
	} tcw_cmd_t;

	typedef struct packed {
		logic [ROW_W-1:0] cursor_row;
		logic [COL_W-1:0] cursor_col;
		logic             scrolled;
		logic [7:0]       cell_char;
		logic [7:0]       cell_attr;
	} tcw_res_t;

	typedef struct packed {
		logic clearing;  // clearing pass after reset in progress
	} tcw_back_stat_t;

endpackage
`default_nettype wire

/* hdl/tcw_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_front - request front end
// Holds the cursor, the top-row offset of the circular grid and the
// attribute register; turns each request into a cell-store command.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_write,
	input  wire logic [7:0]        cfg_data,
	input  wire logic              push,
	input  wire logic              opcode,
	input  wire logic [7:0]        char_code,
	input  wire logic [ROW_W-1:0]  read_row,
	input  wire logic [COL_W-1:0]  read_column,
	output logic                   full,
	input  wire tcw_back_stat_t    back_stat,
	input  wire logic              q_full,
	output logic                   cmd_push,
	output tcw_cmd_t               cmd
);

	logic [ROW_W-1:0]  cursor_row_q;
	logic [COL_W-1:0]  cursor_col_q;
	logic [ROW_W-1:0]  top_q;
	logic [7:0]        attr_q;

	logic [ROW_W-1:0]  sel_row;
	logic [COL_W-1:0]  sel_col;
	logic [ROW_W:0]    prow_sum;
	logic [ROW_W-1:0]  prow;
	logic [ADDR_W-1:0] cell_addr;
	logic              in_range;
	logic              wrap;
	logic [ROW_W-1:0]  n_row;
	logic [COL_W-1:0]  n_col;
	logic [ROW_W-1:0]  n_top;

	assign full     = back_stat.clearing | q_full;
	assign cmd_push = push & ~full;

	// map a logical row onto the circular store
	assign sel_row   = (opcode == OP_READ) ? read_row : cursor_row_q;
	assign sel_col   = (opcode == OP_READ) ? read_column : cursor_col_q;
	assign prow_sum  = {1'b0, sel_row} + {1'b0, top_q};
	assign prow      = (prow_sum >= (ROW_W+1)'(ROWS)) ?
		ROW_W'(prow_sum - (ROW_W+1)'(ROWS)) : prow_sum[ROW_W-1:0];
	assign cell_addr = ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(sel_col);
	assign in_range  = ({1'b0, read_row} < (ROW_W+1)'(ROWS)) &&
		({1'b0, read_column} < (COL_W+1)'(COLUMNS));

	always_comb begin
		cmd   = '0;
		wrap  = 1'b0;
		n_row = cursor_row_q;
		n_col = cursor_col_q;
		n_top = top_q;
		if (opcode == OP_READ) begin
			cmd.rd_en = in_range;
			cmd.addr  = cell_addr;
		end else begin
			case (char_code)
				CHAR_NEWLINE: begin
					wrap  = 1'b1;
					n_col = '0;
				end
				CHAR_RETURN: begin
					n_col = '0;
				end
				default: begin
					cmd.wr_en = 1'b1;
					cmd.addr  = cell_addr;
					cmd.data  = {attr_q, char_code};
					if (cursor_col_q == COL_W'(COLUMNS - 1)) begin
						n_col = '0;
						wrap  = 1'b1;
					end else begin
						n_col = cursor_col_q + COL_W'(1);
					end
				end
			endcase
			if (wrap) begin
				if (cursor_row_q == ROW_W'(ROWS - 1)) begin
					// scroll: the old top row becomes the blank last row
					cmd.blank      = 1'b1;
					cmd.blank_base = ADDR_W'(top_q) * ADDR_W'(COLUMNS);
					cmd.blank_attr = attr_q;
					cmd.scrolled   = 1'b1;
					n_top = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + ROW_W'(1);
					n_row = ROW_W'(ROWS - 1);
					n_col = '0;
				end else begin
					n_row = cursor_row_q + ROW_W'(1);
				end
			end
		end
		cmd.cursor_row = n_row;
		cmd.cursor_col = n_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_row_q <= '0;
			cursor_col_q <= '0;
			top_q        <= '0;
			attr_q       <= ATTR_DEFAULT;
		end else begin
			if (cmd_push) begin
				cursor_row_q <= n_row;
				cursor_col_q <= n_col;
				top_q        <= n_top;
			end
			if (cfg_write) begin
				attr_q <= cfg_data;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/tcw_cmd_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_cmd_queue - command queue
// Short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module tcw_cmd_queue import tcw_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     wr,
	input  wire tcw_cmd_t wr_data,
	output logic          q_full,
	input  wire logic     rd,
	output tcw_cmd_t      rd_data,
	output logic          q_empty
);

	tcw_cmd_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign q_full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/tcw_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_back - cell-store back end
// Owns the cell store; clears it after reset, then executes queued commands
// (cell write, row blanking, cell read) and holds one result for the output.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_empty,
	input  wire tcw_cmd_t   cmd,
	output logic            cmd_pop,
	output tcw_back_stat_t  back_stat,
	output logic            res_valid,
	input  wire logic       res_pop,
	output tcw_res_t        res
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BLANK,
		ST_READ
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] addr_q;
	logic [COL_W-1:0]  col_q;
	logic [7:0]        blank_attr_q;
	logic              res_valid_q;
	tcw_res_t          res_q;

	logic [15:0]       mem [CELL_COUNT];
	logic [15:0]       rd_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [15:0]       mem_wdata;
	logic              take;

	assign take      = (state_q == ST_IDLE) && !q_empty && (!res_valid_q || res_pop);
	assign cmd_pop   = take;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign back_stat.clearing = (state_q == ST_CLEAR);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = CELL_RESET;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				mem_we    = take & cmd.wr_en;
				mem_waddr = cmd.addr;
				mem_wdata = cmd.data;
			end
			ST_BLANK: begin
				mem_we    = 1'b1;
				mem_wdata = {blank_attr_q, CHAR_BLANK};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[cmd.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			addr_q       <= '0;
			col_q        <= '0;
			blank_attr_q <= '0;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			if (res_pop) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + ADDR_W'(1);
					if (addr_q == ADDR_W'(CELL_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						res_q.cursor_row <= cmd.cursor_row;
						res_q.cursor_col <= cmd.cursor_col;
						res_q.scrolled   <= cmd.scrolled;
						res_q.cell_char  <= '0;
						res_q.cell_attr  <= '0;
						if (cmd.blank) begin
							addr_q       <= cmd.blank_base;
							col_q        <= '0;
							blank_attr_q <= cmd.blank_attr;
							state_q      <= ST_BLANK;
						end else if (cmd.rd_en) begin
							state_q <= ST_READ;
						end else begin
							res_valid_q <= 1'b1;
						end
					end
				end
				ST_BLANK: begin
					addr_q <= addr_q + ADDR_W'(1);
					col_q  <= col_q + COL_W'(1);
					if (col_q == COL_W'(COLUMNS - 1)) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_READ: begin
					res_q.cell_char <= rd_q[7:0];
					res_q.cell_attr <= rd_q[15:8];
					res_valid_q     <= 1'b1;
					state_q         <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* hdl/text_console_writer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_top - text-mode console writer
// Character grid with cursor, newline / carriage return handling and
// scrolling; put requests update the grid, read requests return one cell.
// ----------------------------------------------------------------------------
//
//  channel   handshake         payload
//  --------  ----------------  ---------------------------------------------
//  request   push / full       opcode, char_code, read_row, read_column
//  result    empty / pop       cursor_row, cursor_column, scrolled,
//                              cell_char, cell_attr
//  config    cfg_write         cfg_data (text attribute)
//
//  Back-end work per request: a put without scroll and a newline or
//  carriage return finish in the idle state, a read passes through
//  the read state (registered read data), and a request that scrolls
//  runs the blanking state, writing the blanked row one cell per cycle.
//  After reset a clearing pass writes all CELL_COUNT (2000) cells, one per
//  cycle, and full stays high until it ends; cfg_write is taken throughout.
//  A four-entry command queue lets requests enter while a result waits.
//
module text_console_writer_top import tcw_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_write,
	input  wire logic [7:0]        cfg_data,
	input  wire logic              push,
	output logic                   full,
	input  wire logic              opcode,
	input  wire logic [7:0]        char_code,
	input  wire logic [ROW_W-1:0]  read_row,
	input  wire logic [COL_W-1:0]  read_column,
	output logic                   empty,
	input  wire logic              pop,
	output logic [ROW_W-1:0]       cursor_row,
	output logic [COL_W-1:0]       cursor_column,
	output logic                   scrolled,
	output logic [7:0]             cell_char,
	output logic [7:0]             cell_attr
);

	tcw_back_stat_t back_stat;
	tcw_cmd_t       fe_cmd;
	tcw_cmd_t       q_cmd;
	tcw_res_t       res;
	logic           cmd_push;
	logic           cmd_pop;
	logic           q_full;
	logic           q_empty;
	logic           res_valid;
	logic           res_pop;

	// classify requests and advance the cursor
	tcw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.push        (push),
		.opcode      (opcode),
		.char_code   (char_code),
		.read_row    (read_row),
		.read_column (read_column),
		.full        (full),
		.back_stat   (back_stat),
		.q_full      (q_full),
		.cmd_push    (cmd_push),
		.cmd         (fe_cmd)
	);

	// hold commands until the cell store is free
	tcw_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_push),
		.wr_data (fe_cmd),
		.q_full  (q_full),
		.rd      (cmd_pop),
		.rd_data (q_cmd),
		.q_empty (q_empty)
	);

	// drop a result only when it is actually taken
	assign res_pop = pop & res_valid;

	tcw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.cmd       (q_cmd),
		.cmd_pop   (cmd_pop),
		.back_stat (back_stat),
		.res_valid (res_valid),
		.res_pop   (res_pop),
		.res       (res)
	);

	assign empty         = ~res_valid;
	assign cursor_row    = res.cursor_row;
	assign cursor_column = res.cursor_col;
	assign scrolled      = res.scrolled;
	assign cell_char     = res.cell_char;
	assign cell_attr     = res.cell_attr;

	// no request may enter during the clearing pass
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.clearing |-> full)
		else $error("request accepted during clearing pass");

	// the front end never overfills the command queue
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !q_full)
		else $error("command queue overflow");

	// a shown cursor is always on the grid
	a_cursor_on_grid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (cursor_row < ROW_W'(ROWS)) && (cursor_column < COL_W'(COLUMNS)))
		else $error("cursor off the grid");

	// a scroll leaves the cursor at the start of the last row
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && scrolled) |-> (cursor_row == ROW_W'(ROWS - 1)) && (cursor_column == '0))
		else $error("scroll left cursor misplaced");

endmodule
`default_nettype wire

/* dv/tb_text_console_writer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_top - self-checking bench for the text console writer
// A request queue feeds a clocked driver, and a clocked monitor drains the
// result side. A shadow copy of the grid, the cursor and the attribute
// predicts every result. Results are compared field by field in order.
// ----------------------------------------------------------------------------
module tb_text_console_writer_top;
	import tcw_pkg::*;

	// settle time before a register write; covers the blanking of a scroll
	localparam int SETTLE_CYCLES = COLUMNS + 8;
	localparam int RANDOM_REQUESTS = 540;

	typedef enum logic [1:0] {
		STIM_REQUEST,
		STIM_ATTR,
		STIM_DRAIN
	} stim_kind_t;

	typedef struct {
		stim_kind_t       kind;
		logic             op;
		logic [7:0]       ch;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [7:0]       attr;
		int unsigned      gap;
	} stim_t;

	// DUT connections; every input starts at a known value
	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             cfg_write   = 1'b0;
	logic [7:0]       cfg_data    = ATTR_DEFAULT;
	logic             push        = 1'b0;
	logic             full;
	logic             opcode      = OP_PUT;
	logic [7:0]       char_code   = 8'h00;
	logic [ROW_W-1:0] read_row    = '0;
	logic [COL_W-1:0] read_column = '0;
	logic             empty;
	logic             pop         = 1'b0;
	logic [ROW_W-1:0] cursor_row;
	logic [COL_W-1:0] cursor_column;
	logic             scrolled;
	logic [7:0]       cell_char;
	logic [7:0]       cell_attr;

	// shadow state of the console
	logic [15:0] screen_model [CELL_COUNT];
	int          cur_row;
	int          cur_col;
	logic [7:0]  attr_model;

	stim_t       request_queue [$];
	tcw_res_t    expected_results [$];
	int          fail_count = 0;

	// driver and monitor bookkeeping
	stim_t       active_req;
	logic        next_push;
	logic        next_cfg;
	int unsigned gap_count = 0;
	int unsigned settle_count = 0;
	int unsigned stall_count = 0;
	bit          rx_calm = 1'b0;
	bit          tx_calm = 1'b0;
	int          queued_requests = 0;

	text_console_writer_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.opcode        (opcode),
		.char_code     (char_code),
		.read_row      (read_row),
		.read_column   (read_column),
		.empty         (empty),
		.pop           (pop),
		.cursor_row    (cursor_row),
		.cursor_column (cursor_column),
		.scrolled      (scrolled),
		.cell_char     (cell_char),
		.cell_attr     (cell_attr)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hold reset at the start, then release it for good
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Advance the shadow console by one accepted request and return the
	// result it must produce.
	function automatic tcw_res_t advance_console(stim_t req);
		tcw_res_t res;
		int       i;
		res = '0;
		if (req.op == OP_READ) begin
			// out-of-range reads return an all-zero cell
			if (req.row < ROWS && req.col < COLUMNS) begin
				res.cell_char = screen_model[req.row * COLUMNS + req.col][7:0];
				res.cell_attr = screen_model[req.row * COLUMNS + req.col][15:8];
			end
		end else begin
			if (req.ch == CHAR_NEWLINE) begin
				cur_row++;
				cur_col = 0;
			end else if (req.ch == CHAR_RETURN) begin
				cur_col = 0;
			end else begin
				screen_model[cur_row * COLUMNS + cur_col] = {attr_model, req.ch};
				cur_col++;
				// wrap past the last column onto the next row
				if (cur_col >= COLUMNS) begin
					cur_col = 0;
					cur_row++;
				end
			end
			// cursor fell off the bottom: move every row up, blank the last
			if (cur_row >= ROWS) begin
				for (i = 0; i < CELL_COUNT - COLUMNS; i++)
					screen_model[i] = screen_model[i + COLUMNS];
				for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
					screen_model[i] = {attr_model, CHAR_BLANK};
				cur_row = ROWS - 1;
				cur_col = 0;
				res.scrolled = 1'b1;
			end
		end
		res.cursor_row = cur_row[ROW_W-1:0];
		res.cursor_col = cur_col[COL_W-1:0];
		return res;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// --- stimulus builders ---------------------------------------------------
	// The sender gap is drawn here, per request; a calm stretch has none.
	function automatic int unsigned draw_gap();
		return tx_calm ? 0 : $urandom_range(0, 7);
	endfunction

	task automatic add_put(logic [7:0] ch);
		stim_t s;
		s.kind = STIM_REQUEST;
		s.op   = OP_PUT;
		s.ch   = ch;
		// unused coordinates still carry random bits
		s.row  = ROW_W'($urandom);
		s.col  = COL_W'($urandom);
		s.attr = '0;
		s.gap  = draw_gap();
		request_queue.push_back(s);
		queued_requests++;
	endtask

	task automatic add_read(int row, int col);
		stim_t s;
		s.kind = STIM_REQUEST;
		s.op   = OP_READ;
		s.ch   = 8'($urandom);
		s.row  = ROW_W'(row);
		s.col  = COL_W'(col);
		s.attr = '0;
		s.gap  = draw_gap();
		request_queue.push_back(s);
		queued_requests++;
	endtask

	task automatic add_drain();
		stim_t s;
		s = '{kind: STIM_DRAIN, op: OP_PUT, ch: '0, row: '0, col: '0, attr: '0, gap: 0};
		request_queue.push_back(s);
	endtask

	// the attribute only changes once the block has gone quiet
	task automatic change_attr(logic [7:0] value);
		stim_t s;
		add_drain();
		s = '{kind: STIM_ATTR, op: OP_PUT, ch: '0, row: '0, col: '0, attr: value, gap: 0};
		request_queue.push_back(s);
	endtask

	// --- driver ----------------------------------------------------------------
	// Predict at the edge a request is taken; drop push only when nothing
	// follows straight away, so push is never lowered and raised in one step.
	always @(posedge clk) begin
		if (!arst_n) begin
			push      <= 1'b0;
			cfg_write <= 1'b0;
			gap_count    = 0;
			settle_count = 0;
		end else begin
			next_push = push;
			next_cfg  = 1'b0;
			if (push && !full) begin
				expected_results.push_back(advance_console(active_req));
				next_push = 1'b0;
			end
			if (!next_push && request_queue.size() != 0) begin
				case (request_queue[0].kind)
					STIM_REQUEST: begin
						if (gap_count < request_queue[0].gap) begin
							gap_count++;
						end else begin
							active_req = request_queue.pop_front();
							opcode      <= active_req.op;
							char_code   <= active_req.ch;
							read_row    <= active_req.row;
							read_column <= active_req.col;
							next_push = 1'b1;
							gap_count = 0;
						end
					end
					STIM_ATTR: begin
						attr_model = request_queue[0].attr;
						cfg_data <= request_queue[0].attr;
						next_cfg = 1'b1;
						request_queue.delete(0);
					end
					default: begin
						// hold off until every result is back, then let it settle
						if (expected_results.size() != 0) begin
							settle_count = 0;
						end else if (settle_count < SETTLE_CYCLES) begin
							settle_count++;
						end else begin
							settle_count = 0;
							request_queue.delete(0);
						end
					end
				endcase
			end
			push      <= next_push;
			cfg_write <= next_cfg;
		end
	end

	// --- monitor ---------------------------------------------------------------
	// Compare each taken result with the oldest prediction, then draw a stall.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
			stall_count = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$error("result taken with no request outstanding");
					fail_count++;
				end else begin
					check_field("cursor_row", 16'(expected_results[0].cursor_row),
						16'(cursor_row));
					check_field("cursor_column", 16'(expected_results[0].cursor_col),
						16'(cursor_column));
					check_field("scrolled", 16'(expected_results[0].scrolled),
						16'(scrolled));
					check_field("cell_char", 16'(expected_results[0].cell_char),
						16'(cell_char));
					check_field("cell_attr", 16'(expected_results[0].cell_attr),
						16'(cell_attr));
					expected_results.delete(0);
				end
				// switch between stalling and calm stretches now and then
				if ($urandom_range(0, 31) == 0)
					rx_calm = !rx_calm;
				stall_count = rx_calm ? 0 : $urandom_range(0, 7);
			end
			if (stall_count > 0) begin
				stall_count--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// --- stimulus and end of run -----------------------------------------------
	initial begin
		int          i;
		int          n;
		int          target;
		logic [7:0]  ch;
		int unsigned pick;

		for (i = 0; i < CELL_COUNT; i++)
			screen_model[i] = CELL_RESET;
		cur_row    = 0;
		cur_col    = 0;
		attr_model = ATTR_DEFAULT;

		// reset contents, grid corners and out-of-range reads
		add_read(0, 0);
		add_read(ROWS - 1, COLUMNS - 1);
		add_read(ROWS, 0);
		add_read(0, COLUMNS);
		add_read((1 << ROW_W) - 1, (1 << COL_W) - 1);

		// plain characters at the byte extremes, carriage return, newline
		change_attr(8'hFF);
		add_put(8'h41);
		add_put(8'h00);
		add_put(8'hFF);
		add_put(CHAR_RETURN);
		add_put(8'h7E);
		add_put(CHAR_NEWLINE);
		add_put(CHAR_BLANK);
		add_read(0, 0);
		add_read(0, 1);
		add_read(0, 2);
		add_read(1, 0);
		change_attr(8'h00);
		add_put(8'h80);
		add_read(1, 1);

		// fill the rest of row 1 to wrap, then newline down past the last row
		for (i = 2; i < COLUMNS; i++)
			add_put(8'($urandom_range(32, 126)));
		for (i = 2; i <= ROWS; i++)
			add_put(CHAR_NEWLINE);
		add_read(0, 0);
		add_read(ROWS - 1, 0);
		// a full last row wraps and scrolls by itself
		change_attr(8'($urandom));
		for (i = 0; i < COLUMNS; i++)
			add_put(8'($urandom_range(32, 126)));
		add_read(ROWS - 2, 0);
		add_read(ROWS - 2, COLUMNS - 1);
		add_read(ROWS - 1, 0);

		// random part: mostly text lines and newline runs with random content
		target = queued_requests + RANDOM_REQUESTS;
		while (queued_requests < target) begin
			if ($urandom_range(0, 11) == 0) begin
				pick = $urandom_range(0, 2);
				change_attr(pick == 0 ? 8'h00 : (pick == 1 ? 8'hFF : 8'($urandom)));
			end
			tx_calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					n = $urandom_range(1, COLUMNS + 20);
					for (i = 0; i < n; i++) begin
						ch = 8'($urandom);
						if (ch == CHAR_NEWLINE || ch == CHAR_RETURN)
							ch = 8'h2E;
						add_put(ch);
					end
					pick = $urandom_range(0, 2);
					if (pick == 0)
						add_put(CHAR_NEWLINE);
					else if (pick == 1)
						add_put(CHAR_RETURN);
				end
				4, 5: begin
					n = $urandom_range(1, ROWS + 5);
					for (i = 0; i < n; i++)
						add_put($urandom_range(0, 3) == 0 ? CHAR_RETURN : CHAR_NEWLINE);
				end
				6, 7: begin
					n = $urandom_range(1, 8);
					for (i = 0; i < n; i++) begin
						if ($urandom_range(0, 3) == 0)
							add_read($urandom, $urandom);
						else
							add_read($urandom_range(0, ROWS - 1),
								$urandom_range(0, COLUMNS - 1));
					end
				end
				8: begin
					// noise: any opcode, any byte, any coordinates
					n = $urandom_range(1, 10);
					for (i = 0; i < n; i++) begin
						pick = $urandom_range(0, 7);
						ch = (pick == 0) ? CHAR_NEWLINE : (pick == 1 ? CHAR_RETURN
							: 8'($urandom));
						if ($urandom_range(0, 1) == 0)
							add_put(ch);
						else
							add_read($urandom, $urandom);
					end
				end
				default: begin
					// let the pipeline run dry before carrying on
					add_drain();
				end
			endcase
		end
		change_attr(ATTR_DEFAULT);
		add_put(8'h5A);
		add_read(0, 0);

		// wait for the queue to empty and every result to come back
		while (request_queue.size() != 0 || push || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			fail_count++;
		end

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

endmodule

/* sim.f */
hdl/tcw_pkg.sv
hdl/tcw_front.sv
hdl/tcw_cmd_queue.sv
hdl/tcw_back.sv
hdl/text_console_writer_top.sv
dv/tb_text_console_writer_top.sv
